FILE: design/matrix_multiply_transpose_accumulate_assert.svh
// Assertion macros shared by the matrix multiply block.
// No dependencies.
`ifndef MATRIX_MULTIPLY_TRANSPOSE_ACCUMULATE_ASSERT_SVH
`define MATRIX_MULTIPLY_TRANSPOSE_ACCUMULATE_ASSERT_SVH
// implication checked every clock outside reset
`define MMTA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MMTA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: design/mmta_pkg.sv
// Package for the matrix multiply block: types, constants, codes.
// No dependencies.
`default_nettype none
package mmta_pkg;
    localparam int DIM_MAX_DEF     = 16;
    localparam int ELEM_COUNT_DEF  = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int ACC_W           = 128;

    typedef enum logic [2:0] {
        FN_LOAD_A  = 3'd0,
        FN_LOAD_B  = 3'd1,
        FN_LOAD_C  = 3'd2,
        FN_COMPUTE = 3'd3,
        FN_READ_C  = 3'd4
    } func_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [1:0] MODE_SET = 2'd0;
    localparam logic [1:0] MODE_ADD = 2'd1;
    localparam logic [1:0] MODE_SUB = 2'd2;

    localparam logic [2:0] REG_A_ROWS = 3'd0;
    localparam logic [2:0] REG_A_COLS = 3'd1;
    localparam logic [2:0] REG_B_ROWS = 3'd2;
    localparam logic [2:0] REG_B_COLS = 3'd3;
    localparam logic [2:0] REG_TR_A   = 3'd4;
    localparam logic [2:0] REG_TR_B   = 3'd5;
    localparam logic [2:0] REG_TR_C   = 3'd6;
    localparam logic [2:0] REG_MODE   = 3'd7;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         addr;
        logic signed [31:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
    } out_beat_t;

    typedef struct packed {
        logic [4:0] a_rows;
        logic [4:0] a_cols;
        logic [4:0] b_rows;
        logic [4:0] b_cols;
        logic       tr_a;
        logic       tr_b;
        logic       tr_c;
        logic [1:0] mode;
    } cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_SIMPLE, BK_RD_WAIT, BK_FETCH, BK_MUL, BK_ACC,
        BK_ROUND, BK_CREAD, BK_CWAIT, BK_COMB, BK_WRITE, BK_OUT
    } bk_state_t;
endpackage
`default_nettype wire

FILE: design/mmta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mmta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: design/mmta_front.sv
// Front end: accepts beats and holds them in a short queue for the back end.
// Depends on mmta_pkg and matrix_multiply_transpose_accumulate_assert.svh.
`default_nettype none
module mmta_front #(
    parameter int QDEPTH = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mmta_pkg::in_beat_t s_data,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output mmta_pkg::in_beat_t     q_data
);
    import mmta_pkg::*;
    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    in_beat_t q_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic push;

    assign s_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_data  = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == PW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (q_pop) rp_reg <= (rp_reg == PW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop && q_valid);
        end
        if (push) q_reg[wp_reg] <= s_data;
    end

    `include "matrix_multiply_transpose_accumulate_assert.svh"
    `MMTA_ASSERT_IMPL(a_no_overflow, aclk, aresetn, cnt_reg == (PW+1)'(QDEPTH), !push)
    `MMTA_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, cnt_reg <= (PW+1)'(QDEPTH))
    `MMTA_ASSERT_IMPL(a_pop_valid, aclk, aresetn, q_pop, q_valid)
endmodule
`default_nettype wire

FILE: design/mmta_back.sv
// Back end: loads, reads and the multiply-accumulate sequencer over the stores.
// Depends on mmta_pkg, mmta_ram and matrix_multiply_transpose_accumulate_assert.svh.
`default_nettype none
module mmta_back #(
    parameter int DIM_MAX     = mmta_pkg::DIM_MAX_DEF,
    parameter int ELEM_COUNT  = mmta_pkg::ELEM_COUNT_DEF,
    parameter int VALUE_WIDTH = mmta_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mmta_pkg::cfg_t     cfg,
    input  wire logic               q_valid,
    input  wire mmta_pkg::in_beat_t q_data,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mmta_pkg::out_beat_t     m_data
);
    import mmta_pkg::*;
    localparam int AW = $clog2(ELEM_COUNT);
    localparam int DW = $clog2(DIM_MAX + 1);
    localparam int NW = 2 * DW;
    localparam int VW = VALUE_WIDTH;
    localparam int FB = VALUE_WIDTH / 2;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam logic signed [ACC_W-1:0] VMAX = ACC_W'((128'sd1 <<< (VW-1)) - 1);
    localparam logic signed [ACC_W-1:0] VMIN = -(ACC_W'(128'sd1 <<< (VW-1)));

    function automatic logic [DW-1:0] dim_fix(input logic [4:0] v);
        if (v == 5'd0) return DW'(1);
        if (32'(v) > DIM_MAX) return DW'(DIM_MAX);
        return DW'(v);
    endfunction

    function automatic logic [VW-1:0] sat_v(input logic signed [ACC_W-1:0] x);
        if (x > VMAX) return VMAX[VW-1:0];
        if (x < VMIN) return VMIN[VW-1:0];
        return x[VW-1:0];
    endfunction

    logic [DW-1:0] ar, ac, br, bc, pr, pc, ka, kb;
    always_comb begin
        ar = dim_fix(cfg.a_rows); ac = dim_fix(cfg.a_cols);
        br = dim_fix(cfg.b_rows); bc = dim_fix(cfg.b_cols);
        pr = cfg.tr_a ? ac : ar;  ka = cfg.tr_a ? ar : ac;
        pc = cfg.tr_b ? br : bc;  kb = cfg.tr_b ? bc : br;
    end

    bk_state_t state_reg, state_next;
    logic [DW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] prod_reg;
    logic [VW-1:0] p_reg, p_next;
    logic [NW-1:0] ci_reg, ci_next;
    out_beat_t out_reg, out_next;
    logic ov_reg, ov_next;

    logic a_we, b_we, c_we;
    logic [AW-1:0] a_ra, b_ra, c_ra, c_wa, ld_wa;
    logic [VW-1:0] a_rd, b_rd, c_rd, c_wd;
    logic [NW-1:0] ai, bi, ci, nlim;
    logic in_rng;
    logic [VW+1:0] wide_sum;

    mmta_ram #(.WIDTH(VW), .DEPTH(ELEM_COUNT)) u_a (.aclk(aclk), .we(a_we), .waddr(ld_wa),
        .wdata(q_data.value[VW-1:0]), .raddr(a_ra), .rdata(a_rd));
    mmta_ram #(.WIDTH(VW), .DEPTH(ELEM_COUNT)) u_b (.aclk(aclk), .we(b_we), .waddr(ld_wa),
        .wdata(q_data.value[VW-1:0]), .raddr(b_ra), .rdata(b_rd));
    mmta_ram #(.WIDTH(VW), .DEPTH(ELEM_COUNT)) u_c (.aclk(aclk), .we(c_we), .waddr(c_wa),
        .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

    always_comb begin
        ai = cfg.tr_a ? NW'(k_reg * ac + i_reg) : NW'(i_reg * ac + k_reg);
        bi = cfg.tr_b ? NW'(j_reg * bc + k_reg) : NW'(k_reg * bc + j_reg);
        ci = cfg.tr_c ? NW'(j_reg * pr + i_reg) : NW'(i_reg * pc + j_reg);
        case (func_t'(q_data.func))
            FN_LOAD_A: nlim = NW'(ar * ac);
            FN_LOAD_B: nlim = NW'(br * bc);
            default:   nlim = NW'(pr * pc);
        endcase
        in_rng = (NW'(q_data.addr) < nlim) && (32'(q_data.addr) < ELEM_COUNT);
        ld_wa = AW'(q_data.addr);
        a_ra = AW'(ai); b_ra = AW'(bi);
        c_ra = (state_reg == BK_IDLE) ? AW'(q_data.addr) : AW'(ci_reg);
        if (cfg.mode == MODE_SUB)
            wide_sum = {{2{c_rd[VW-1]}}, c_rd} - {{2{p_reg[VW-1]}}, p_reg};
        else
            wide_sum = {{2{c_rd[VW-1]}}, c_rd} + {{2{p_reg[VW-1]}}, p_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next;
        acc_reg <= acc_next; p_reg <= p_next; ci_reg <= ci_next;
        out_reg <= out_next;
        // a zero is read back for an index past the store
        prod_reg <= $signed(((32'(ai) < ELEM_COUNT) ? a_rd : '0))
                  * $signed(((32'(bi) < ELEM_COUNT) ? b_rd : '0));
    end

    always_comb begin
        logic signed [ACC_W-1:0] rnd;
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg;
        acc_next = acc_reg; p_next = p_reg; ci_next = ci_reg;
        out_next = out_reg; ov_next = ov_reg;
        q_pop = 1'b0; a_we = 1'b0; b_we = 1'b0; c_we = 1'b0;
        c_wa = AW'(ci_reg); c_wd = p_reg;
        rnd = (acc_reg + ACC_W'(128'sd1 <<< (FB-1))) >>> FB;
        if (ov_reg && m_ready) ov_next = 1'b0;
        case (state_reg)
            BK_IDLE: if (q_valid && !ov_reg) begin
                q_pop = 1'b1;
                out_next = '{status: ST_OK, read_value: '0};
                state_next = BK_SIMPLE;
                case (q_data.func)
                    FN_LOAD_A, FN_LOAD_B, FN_LOAD_C: begin
                        if (!in_rng) out_next.status = ST_RANGE;
                        else if (q_data.func == FN_LOAD_A) a_we = 1'b1;
                        else if (q_data.func == FN_LOAD_B) b_we = 1'b1;
                        else begin
                            c_we = 1'b1; c_wa = ld_wa; c_wd = q_data.value[VW-1:0];
                        end
                    end
                    FN_READ_C: begin
                        if (in_rng) state_next = BK_RD_WAIT;
                        else out_next.status = ST_RANGE;
                    end
                    FN_COMPUTE: begin
                        if (ka != kb) out_next.status = ST_MISMATCH;
                        else begin
                            i_next = '0; j_next = '0; k_next = '0;
                            acc_next = '0; state_next = BK_FETCH;
                        end
                    end
                    default: ;
                endcase
            end
            BK_SIMPLE: state_next = BK_OUT;
            BK_RD_WAIT: begin
                out_next.read_value = $signed(32'($signed(c_rd)));
                state_next = BK_OUT;
            end
            BK_FETCH: state_next = BK_MUL;
            BK_MUL:   state_next = BK_ACC;
            BK_ACC: begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (k_reg == ka - 1'b1) state_next = BK_ROUND;
                else begin
                    k_next = k_reg + 1'b1; state_next = BK_FETCH;
                end
            end
            BK_ROUND: begin
                p_next = sat_v(rnd);
                ci_next = ci;
                state_next = BK_CREAD;
            end
            BK_CREAD: state_next = BK_CWAIT;
            BK_CWAIT: state_next = BK_COMB;
            BK_COMB: begin
                if (cfg.mode == MODE_ADD || cfg.mode == MODE_SUB) begin
                    if ($signed(wide_sum) > $signed((VW+2)'(VMAX)))
                        p_next = VMAX[VW-1:0];
                    else if ($signed(wide_sum) < $signed((VW+2)'(VMIN)))
                        p_next = VMIN[VW-1:0];
                    else p_next = wide_sum[VW-1:0];
                end
                state_next = BK_WRITE;
            end
            BK_WRITE: begin
                c_we = (32'(ci_reg) < ELEM_COUNT);
                k_next = '0; acc_next = '0;
                state_next = BK_FETCH;
                if (j_reg == pc - 1'b1) begin
                    j_next = '0;
                    if (i_reg == pr - 1'b1) state_next = BK_OUT;
                    else i_next = i_reg + 1'b1;
                end else j_next = j_reg + 1'b1;
            end
            BK_OUT: if (!ov_reg || m_ready) begin
                ov_next = 1'b1;
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign m_valid = ov_reg;
    assign m_data  = out_reg;

    `include "matrix_multiply_transpose_accumulate_assert.svh"
    `MMTA_ASSERT_IMPL(a_pop_idle, aclk, aresetn, q_pop, state_reg == BK_IDLE)
    `MMTA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `MMTA_ASSERT_IMPL(a_one_write, aclk, aresetn, 1'b1, $countones({a_we, b_we, c_we}) <= 1)
endmodule
`default_nettype wire

FILE: design/matrix_multiply_transpose_accumulate.sv
// Matrix multiply block with operand transposes and C accumulate.
// Top level: APB registers, front queue and back sequencer. Uses mmta_pkg.
// Use: configure dimensions, transposes and result mode over APB while idle,
// then send beats on s_ (func, addr, value). Each beat yields one m_ beat
// with status and read_value. A compute forms its products one at a time
// with the single multiplier and the one-port reads of the A, B and C
// memories, each product taking fetch, multiply and accumulate steps.
// A two-entry queue lets the front take beats while the back works, and
// a result register holds the answer while the receiver stalls; the back
// does not start a new beat until the pending result is taken.
// Reset (aresetn low, synchronous) clears the queue and handshakes and
// sets dimensions to 1, other registers to 0. Store contents are
// undefined until loaded; no clearing pass is run.
// pready is always high; reads return the register's value.
`default_nettype none
module matrix_multiply_transpose_accumulate #(
    parameter int DIM_MAX     = mmta_pkg::DIM_MAX_DEF,
    parameter int ELEM_COUNT  = mmta_pkg::ELEM_COUNT_DEF,
    parameter int VALUE_WIDTH = mmta_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mmta_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mmta_pkg::out_beat_t      m_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import mmta_pkg::*;
    cfg_t cfg_reg;
    logic q_valid, q_pop;
    in_beat_t q_data;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{a_rows: 5'd1, a_cols: 5'd1, b_rows: 5'd1, b_cols: 5'd1,
                         tr_a: 1'b0, tr_b: 1'b0, tr_c: 1'b0, mode: MODE_SET};
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_A_ROWS: cfg_reg.a_rows <= pwdata[4:0];
                REG_A_COLS: cfg_reg.a_cols <= pwdata[4:0];
                REG_B_ROWS: cfg_reg.b_rows <= pwdata[4:0];
                REG_B_COLS: cfg_reg.b_cols <= pwdata[4:0];
                REG_TR_A:   cfg_reg.tr_a   <= pwdata[0];
                REG_TR_B:   cfg_reg.tr_b   <= pwdata[0];
                REG_TR_C:   cfg_reg.tr_c   <= pwdata[0];
                REG_MODE:   cfg_reg.mode   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_A_ROWS: prdata = {27'd0, cfg_reg.a_rows};
            REG_A_COLS: prdata = {27'd0, cfg_reg.a_cols};
            REG_B_ROWS: prdata = {27'd0, cfg_reg.b_rows};
            REG_B_COLS: prdata = {27'd0, cfg_reg.b_cols};
            REG_TR_A:   prdata = {31'd0, cfg_reg.tr_a};
            REG_TR_B:   prdata = {31'd0, cfg_reg.tr_b};
            REG_TR_C:   prdata = {31'd0, cfg_reg.tr_c};
            REG_MODE:   prdata = {30'd0, cfg_reg.mode};
            default:    prdata = '0;
        endcase
    end

    mmta_front #(.QDEPTH(2)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

    mmta_back #(.DIM_MAX(DIM_MAX), .ELEM_COUNT(ELEM_COUNT), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .q_valid(q_valid),
        .q_data(q_data), .q_pop(q_pop), .m_valid(m_valid), .m_ready(m_ready),
        .m_data(m_data));
endmodule
`default_nettype wire

FILE: dv/tb_matrix_multiply_transpose_accumulate.sv
// Testbench for the matrix multiply block: loads, computes and C reads over the
// beat channels with random idling, checked against an in-bench Q16.16 predictor.
// Depends on mmta_pkg and matrix_multiply_transpose_accumulate.
`default_nettype none
module tb_matrix_multiply_transpose_accumulate;
    import mmta_pkg::*;

    localparam int LIMIT = 4000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    always #6 aclk = ~aclk;

    matrix_multiply_transpose_accumulate DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic signed [31:0] a_mem [256];
    logic signed [31:0] b_mem [256];
    logic signed [31:0] c_mem [256];
    logic [4:0] a_rows, a_cols, b_rows, b_cols;
    logic tr_a, tr_b, tr_c;
    logic [1:0] mode;

    out_beat_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    int n_sent = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold = 0;

    task automatic report(input string what, input out_beat_t got, input out_beat_t exp);
        $display("mismatch %s: got status %0d value %h, want status %0d value %h",
                 what, got.status, got.read_value, exp.status, exp.read_value);
        errors++;
    endtask

    function automatic int eff_dim(input logic [4:0] v);
        if (v == 0) return 1;
        return (v > 16) ? 16 : int'(v);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
        if (x > 128'sd2147483647) return 32'sh7fffffff;
        if (x < -128'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic out_beat_t predict_beat(input in_beat_t b);
        out_beat_t r;
        int ar, ac, br, bc, pr, pc, ka, kb, n, ci, ai, bi;
        logic signed [127:0] acc, prod;
        logic signed [31:0] p;
        ar = eff_dim(a_rows); ac = eff_dim(a_cols);
        br = eff_dim(b_rows); bc = eff_dim(b_cols);
        pr = tr_a ? ac : ar; ka = tr_a ? ar : ac;
        pc = tr_b ? br : bc; kb = tr_b ? bc : br;
        r = '0;
        case (b.func)
            FN_LOAD_A, FN_LOAD_B, FN_LOAD_C: begin
                n = (b.func == FN_LOAD_A) ? ar * ac : (b.func == FN_LOAD_B) ? br * bc : pr * pc;
                if (b.addr < n) begin
                    if (b.func == FN_LOAD_A) a_mem[b.addr] = b.value;
                    else if (b.func == FN_LOAD_B) b_mem[b.addr] = b.value;
                    else c_mem[b.addr] = b.value;
                end else r.status = ST_RANGE;
            end
            FN_COMPUTE: begin
                if (ka != kb) r.status = ST_MISMATCH;
                else begin
                    for (int i = 0; i < pr; i++)
                        for (int j = 0; j < pc; j++) begin
                            acc = '0;
                            ci = tr_c ? j * pr + i : i * pc + j;
                            for (int k = 0; k < ka; k++) begin
                                ai = tr_a ? k * ac + i : i * ac + k;
                                bi = tr_b ? j * bc + k : k * bc + j;
                                prod = 128'(a_mem[ai]) * 128'(b_mem[bi]);
                                acc = acc + prod;
                            end
                            acc = (acc + 128'sd32768) >>> 16;
                            p = clamp32(acc);
                            if (mode == MODE_ADD) p = clamp32(128'(c_mem[ci]) + 128'(p));
                            else if (mode == MODE_SUB) p = clamp32(128'(c_mem[ci]) - 128'(p));
                            c_mem[ci] = p;
                        end
                end
            end
            FN_READ_C: begin
                if (b.addr < pr * pc) r.read_value = c_mem[b.addr];
                else r.status = ST_RANGE;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected beat", m_data, '0);
            end else begin
                out_beat_t e;
                e = pending_results.pop_front();
                if (m_data.status !== e.status) report("status", m_data, e);
                else if (m_data.read_value !== e.read_value) report("read_value", m_data, e);
            end
        end
    end

    // receiver stall driver
    int rx_gap = 0;
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else m_ready <= 1'b1;
    end

    // valid stays up after a beat; whoever waits next drops it
    task automatic send_beat(input in_beat_t b);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        pending_results.push_back(predict_beat(b));
        n_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        s_valid <= 1'b0;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_A_ROWS: a_rows = v[4:0];
            REG_A_COLS: a_cols = v[4:0];
            REG_B_ROWS: b_rows = v[4:0];
            REG_B_COLS: b_cols = v[4:0];
            REG_TR_A:   tr_a = v[0];
            REG_TR_B:   tr_b = v[0];
            REG_TR_C:   tr_c = v[0];
            default:    mode = v[1:0];
        endcase
    endtask

    task automatic set_shape(input int ar, ac, br, bc, input bit ta, tb, tc, input int md);
        reg_write(REG_A_ROWS, ar); reg_write(REG_A_COLS, ac);
        reg_write(REG_B_ROWS, br); reg_write(REG_B_COLS, bc);
        reg_write(REG_TR_A, 32'(ta)); reg_write(REG_TR_B, 32'(tb));
        reg_write(REG_TR_C, 32'(tc)); reg_write(REG_MODE, md);
    endtask

    function automatic logic signed [31:0] rand_val(input bit big);
        if (big) return $urandom;
        return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endfunction

    function automatic in_beat_t mk(input func_t f, input int a, input logic signed [31:0] v);
        in_beat_t b;
        b.func = f; b.addr = 8'(a); b.value = v;
        return b;
    endfunction

    // fill every element that the current shape can touch (A, B and C)
    task automatic fill_all(input bit big);
        for (int i = 0; i < eff_dim(a_rows) * eff_dim(a_cols); i++)
            send_beat(mk(FN_LOAD_A, i, rand_val(big)));
        for (int i = 0; i < eff_dim(b_rows) * eff_dim(b_cols); i++)
            send_beat(mk(FN_LOAD_B, i, rand_val(big)));
        for (int i = 0; i < 256; i++)
            if (i < (tr_a ? eff_dim(a_cols) : eff_dim(a_rows))
                    * (tr_b ? eff_dim(b_rows) : eff_dim(b_cols)))
                send_beat(mk(FN_LOAD_C, i, rand_val(big)));
    endtask

    task automatic test_directed;
        set_shape(2, 2, 2, 2, 0, 0, 0, MODE_SET);
        send_beat(mk(FN_LOAD_A, 0, 32'sh7fffffff));
        send_beat(mk(FN_LOAD_A, 1, 32'sh80000000));
        send_beat(mk(FN_LOAD_A, 2, 32'sh00010000));
        send_beat(mk(FN_LOAD_A, 3, 32'shffff8000));
        send_beat(mk(FN_LOAD_B, 0, 32'sh7fffffff));
        send_beat(mk(FN_LOAD_B, 1, 32'sh00000001));
        send_beat(mk(FN_LOAD_B, 2, 32'sh80000000));
        send_beat(mk(FN_LOAD_B, 3, 32'sh00008000));
        send_beat(mk(FN_LOAD_C, 3, 32'sh7fffffff));
        send_beat(mk(FN_LOAD_A, 4, 0));          // out of range
        send_beat(mk(FN_LOAD_C, 255, -1));       // out of range
        send_beat(mk(FN_COMPUTE, 0, 0));
        for (int i = 0; i < 4; i++) send_beat(mk(FN_READ_C, i, 0));
        send_beat(mk(FN_READ_C, 4, 0));
        send_beat(mk(func_t'(3'd5), 8'hff, -1)); // unused funcs
        send_beat(mk(func_t'(3'd7), 0, 32'sh55aa55aa));
        drain();
        set_shape(2, 3, 2, 2, 0, 0, 0, MODE_ADD);
        send_beat(mk(FN_COMPUTE, 0, 0));         // inner mismatch
        drain();
    endtask

    task automatic test_extremes;
        set_shape(16, 16, 16, 16, 1, 1, 1, MODE_SUB);
        fill_all(1);
        send_beat(mk(FN_COMPUTE, 0, 0));
        send_beat(mk(FN_READ_C, 0, 0));
        send_beat(mk(FN_READ_C, 255, 0));
        drain();
        // out-of-range dimension codes: 0 acts as 1, above 16 acts as 16
        set_shape(0, 31, 17, 0, 1, 0, 0, 3);
        fill_all(0);
        send_beat(mk(FN_COMPUTE, 0, 0));
        for (int i = 0; i < 16; i++) send_beat(mk(FN_READ_C, i, 0));
        send_beat(mk(FN_READ_C, 16, 0));
        drain();
    endtask

    task automatic test_backpressure;
        set_shape(1, 1, 1, 1, 0, 0, 0, MODE_SET);
        rx_hold <= 300;
        for (int i = 0; i < 12; i++) send_beat(mk(FN_LOAD_A, $urandom_range(0, 1), rand_val(1)));
        send_beat(mk(FN_LOAD_B, 0, rand_val(0)));
        send_beat(mk(FN_LOAD_C, 0, rand_val(0)));
        drain();
    endtask

    task automatic test_random;
        int ar, ac, k, bc;
        in_beat_t b;
        while (n_sent < 1100) begin
            ar = $urandom_range(1, 5); ac = $urandom_range(1, 5); bc = $urandom_range(1, 5);
            if ($urandom_range(0, 15) == 0) begin
                ar = $urandom_range(1, 8); ac = $urandom_range(1, 8); bc = $urandom_range(1, 8);
            end
            if (n_sent > 950) tx_idle_on = 0;
            if (n_sent > 950) rx_idle_on = 0;
            begin
                bit ta, tb;
                ta = $urandom_range(0, 1); tb = $urandom_range(0, 1);
                k = ta ? ar : ac;
                set_shape(ar, ac, tb ? bc : k, tb ? k : bc, ta, tb, $urandom_range(0, 1),
                          $urandom_range(0, 3));
            end
            fill_all($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                for (int n = 0; n < 6; n++) begin
                    b.func = 3'($urandom_range(0, 7));
                    b.addr = 8'($urandom);
                    b.value = $urandom;
                    if ($urandom_range(0, 3) != 0) b.addr = 8'($urandom_range(0, 30));
                    // loads only land on entries that are already filled
                    if (b.func == FN_COMPUTE && $urandom_range(0, 1)) b.func = FN_READ_C;
                    send_beat(b);
                end
                send_beat(mk(FN_COMPUTE, 0, 0));
            end
            for (int i = 0; i < 4; i++) send_beat(mk(FN_READ_C, $urandom_range(0, 20), 0));
            drain();
            if ($urandom_range(0, 7) == 0) begin
                // sender pause until everything has come back
                while (pending_results.size() != 0) @(posedge aclk);
                // mismatch attempt on the inner dimension of op(B)
                reg_write(tr_b ? REG_B_COLS : REG_B_ROWS, k + 1);
                send_beat(mk(FN_COMPUTE, 0, 0));
                drain();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 256; i++) begin
            a_mem[i] = 0; b_mem[i] = 0; c_mem[i] = 0;
        end
        a_rows = 1; a_cols = 1; b_rows = 1; b_cols = 1;
        tr_a = 0; tr_b = 0; tr_c = 0; mode = MODE_SET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extremes();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+design
design/mmta_pkg.sv
design/mmta_ram.sv
design/mmta_front.sv
design/mmta_back.sv
design/matrix_multiply_transpose_accumulate.sv
dv/tb_matrix_multiply_transpose_accumulate.sv
